// File: rtl/core/crcdf_pkg.sv
// shared types, constants and the crc-8 byte update for the frame deframer
`default_nettype none

package crcdf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned TDATA_W = 56;

    // polynomial x^8 + x^5 + x^4 + 1, msb first
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    // header byte positions within a frame
    localparam logic [POS_W-1:0] POS_KIND     = 9'd0;
    localparam logic [POS_W-1:0] POS_SEQUENCE = 9'd1;
    localparam logic [POS_W-1:0] POS_TOTAL    = 9'd2;
    localparam logic [POS_W-1:0] POS_LENGTH   = 9'd3;
    localparam logic [POS_W-1:0] HDR_LEN      = 9'd4;

    typedef enum logic {
        OUT_PAYLOAD   = 1'b0,
        OUT_FRAME_END = 1'b1
    } t_out_kind;

    typedef struct packed {
        t_out_kind         out_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_kind;
        logic [BYTE_W-1:0] sequence_number;
        logic [BYTE_W-1:0] chunk_total;
        logic [BYTE_W-1:0] payload_length;
        logic              crc_ok;
    } t_result;

    // one byte through the crc, eight shift steps
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/crcdf_in_reg.sv
// input register stage for received bytes
`default_nettype none

module crcdf_in_reg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [crcdf_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_take,
    output logic                            o_valid,
    output logic [crcdf_pkg::BYTE_W-1:0]    o_byte
);
    import crcdf_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // byte payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: rtl/core/crcdf_parse.sv
// frame position tracking, header capture and running crc
`default_nettype none

module crcdf_parse (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_take,
    input  wire logic [crcdf_pkg::BYTE_W-1:0] i_byte,
    output logic                              o_emit,
    output crcdf_pkg::t_result                o_res
);
    import crcdf_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [BYTE_W-1:0] r_kind, n_kind;
    logic [BYTE_W-1:0] r_seq, n_seq;
    logic [BYTE_W-1:0] r_total, n_total;

    logic              is_hdr;
    logic              is_pay;
    logic [BYTE_W-1:0] crc_in;
    logic [BYTE_W-1:0] crc_nx;
    logic [POS_W-1:0]  pay_idx;

    assign is_hdr  = r_pos < HDR_LEN;
    assign is_pay  = !is_hdr && (r_pos < (HDR_LEN + {1'b0, r_len}));
    assign crc_in  = (r_pos == POS_KIND) ? CRC_INIT : r_crc;
    assign crc_nx  = crc8_byte(crc_in, i_byte);
    assign pay_idx = r_pos - HDR_LEN;
    assign o_emit  = !is_hdr;

    // next state and result for the byte in the input register
    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_crc   = r_crc;
        n_kind  = r_kind;
        n_seq   = r_seq;
        n_total = r_total;
        o_res   = '0;
        if (is_hdr) begin
            n_crc = crc_nx;
            n_pos = r_pos + 1'b1;
            unique case (r_pos)
                POS_KIND:     n_kind  = i_byte;
                POS_SEQUENCE: n_seq   = i_byte;
                POS_TOTAL:    n_total = i_byte;
                POS_LENGTH:   n_len   = i_byte;
                default:      n_len   = r_len;
            endcase
        end else if (is_pay) begin
            n_crc               = crc_nx;
            n_pos               = r_pos + 1'b1;
            o_res.out_kind      = OUT_PAYLOAD;
            o_res.payload_byte  = i_byte;
            o_res.payload_index = pay_idx[BYTE_W-1:0];
        end else begin
            n_pos                 = POS_KIND;
            o_res.out_kind        = OUT_FRAME_END;
            o_res.frame_kind      = r_kind;
            o_res.sequence_number = r_seq;
            o_res.chunk_total     = r_total;
            o_res.payload_length  = r_len;
            o_res.crc_ok          = (r_crc == i_byte);
        end
    end

    // parser state, advanced once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_KIND;
            r_len   <= '0;
            r_crc   <= CRC_INIT;
            r_kind  <= '0;
            r_seq   <= '0;
            r_total <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_kind  <= n_kind;
            r_seq   <= n_seq;
            r_total <= n_total;
        end
    end

`ifndef SYNTH
    // position never runs past the crc byte of the current frame
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= (HDR_LEN + {1'b0, r_len}))
        else $error("frame position beyond crc byte");

    // the crc byte sends the parser back to a type byte
    a_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !is_hdr && !is_pay) |=> (r_pos == POS_KIND))
        else $error("frame end did not restart parsing");

    // a new frame restarts the crc from its type byte
    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_pos == POS_KIND) |=> (r_crc == crc8_byte(CRC_INIT, $past(i_byte))))
        else $error("crc not restarted at type byte");
`endif

endmodule

`default_nettype wire

// File: rtl/core/crcdf_out_reg.sv
// result register that holds a result until downstream takes it
`default_nettype none

module crcdf_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire crcdf_pkg::t_result i_res,
    input  wire logic               i_ready,
    output logic                    o_free,
    output logic                    o_valid,
    output crcdf_pkg::t_result      o_res
);
    import crcdf_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: rtl/core/crc8_frame_deframer.sv
// top level of the crc-8 length-prefixed frame deframer
`default_nettype none

// Byte-stream frame deframer. Each byte on the slave stream is parsed by
// position: type, sequence, total and length header bytes, then length payload
// bytes, then one CRC-8 byte (poly 0x31, msb first, init 0, no final xor, over
// header and payload). Header bytes give no result; each payload byte gives a
// result with tuser 0; the crc byte gives a frame-end result with tuser 1 that
// carries the header fields and crc_ok. Frames are assumed back to back with
// no resynchronization. One byte per cycle is sustained while the master stream
// is ready: a byte passes an input register, the parse logic and a result
// register before its result is presented on the master stream, and either
// side may stall at any time.
module crc8_frame_deframer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // rx_byte[7:0]
    input  wire logic [crcdf_pkg::BYTE_W-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // payload_byte[7:0], payload_index[15:8], frame_kind[23:16],
    // sequence_number[31:24], chunk_total[39:32], payload_length[47:40],
    // crc_ok[48], zero[55:49]
    output logic [crcdf_pkg::TDATA_W-1:0]          m_axis_tdata,
    // out_kind[0]
    output logic                                   m_axis_tuser
);
    import crcdf_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              take;
    logic              emit;
    logic              out_free;
    t_result           res;
    t_result           out_res;

    // byte moves on when it makes no result or the result register has room
    assign take = in_valid && (!emit || out_free);

    crcdf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    crcdf_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .o_emit  (emit),
        .o_res   (res)
    );

    crcdf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && emit),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    // pack the result request
    assign m_axis_tdata = {7'd0,
                           out_res.crc_ok,
                           out_res.payload_length,
                           out_res.chunk_total,
                           out_res.sequence_number,
                           out_res.frame_kind,
                           out_res.payload_index,
                           out_res.payload_byte};
    assign m_axis_tuser = out_res.out_kind;

endmodule

`default_nettype wire
